@@ rtl/core/bit_adjacency_neuron_pool_macros.svh @@
// Assertion macros shared by the neuron pool RTL.
`ifndef BIT_ADJACENCY_NEURON_POOL_MACROS_SVH
`define BIT_ADJACENCY_NEURON_POOL_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BITADJ_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BITADJ_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bitadj_pkg.sv @@
// Types, constants and helper functions of the neuron pool.
package bitadj_pkg;

    typedef enum logic [3:0] {
        OP_CLEAR      = 4'd0,
        OP_GROW       = 4'd1,
        OP_CONNECT    = 4'd2,
        OP_DISCONNECT = 4'd3,
        OP_WRITE      = 4'd4,
        OP_READ       = 4'd5,
        OP_DEGREE     = 4'd6,
        OP_SETTLE     = 4'd7,
        OP_HEBBIAN    = 4'd8,
        OP_SEED       = 4'd9
    } opcode_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GROW,
        ST_LINK_RA,
        ST_LINK_WA,
        ST_LINK_RB,
        ST_LINK_WB,
        ST_READ_W,
        ST_DEG,
        ST_SETTLE,
        ST_P_SELF,
        ST_P_SCAN,
        ST_P_DIV,
        ST_COPY,
        ST_STEP_END,
        ST_HEB_I,
        ST_HEB_IW,
        ST_HEB_J,
        ST_HEB_JW,
        ST_SEED,
        ST_FINISH
    } pool_state_t;

    typedef enum logic [1:0] {
        RNG_IDLE,
        RNG_MUL,
        RNG_WARM
    } rng_phase_t;

    typedef struct packed {
        logic seed_go;
        logic draw;
    } rng_ctrl_t;

    typedef struct packed {
        logic busy;
        logic draw_zero;
    } rng_stat_t;

    localparam int          WORD_BITS   = 64;
    localparam logic [7:0]  FIRE_LEVEL  = 8'd128;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;
    localparam logic [6:0]  DEGREE_MAX  = 7'd127;
    localparam logic [63:0] SEED_MUL_B  = 64'd6364136223846793005;
    localparam logic [63:0] SEED_MUL_C  = 64'd1103515245;
    localparam logic [63:0] SEED_ADD_B  = 64'd1;
    localparam logic [63:0] SEED_ADD_C  = 64'd12345;
    localparam logic [63:0] SEED_XOR_D  = 64'hdeadbeefcafebabe;
    localparam logic [6:0]  WARM_DRAWS  = 7'd20;

    function automatic logic [6:0] popcount64(input logic [63:0] w);
        logic [6:0] n;
        n = '0;
        for (int k = 0; k < 64; k++) begin
            n = n + 7'(w[k]);
        end
        return n;
    endfunction

endpackage

@@ rtl/core/bitadj_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bitadj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bitadj_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bitadj_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic             busy_reg, busy_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        den_next   = den_reg;
        shifted    = {rem_reg, q_reg[NUM_W-1]};
        fits       = shifted >= {1'b0, den_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(NUM_W);
            rem_next   = '0;
            q_next     = num;
            den_next   = den;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits DEN_W bits.
            rem_next   = fits ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
            q_next     = {q_reg[NUM_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

@@ rtl/core/bitadj_rng.sv @@
// xoshiro256** generator with a shift-add seeding sequence.
module bitadj_rng (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bitadj_pkg::rng_ctrl_t  ctrl,
    input  logic [63:0]            seed_value,
    output bitadj_pkg::rng_stat_t  stat
);

    bitadj_pkg::rng_phase_t phase_reg, phase_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] c_reg, c_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] m_reg, m_next;
    logic [6:0]  count_reg, count_next;
    logic [63:0] b5;
    logic [63:0] c1, d1, b1, a1, c2;
    logic        step;

    // Only the low three bits of the output are used; they equal bits 59:57 of b*5.
    assign b5 = b_reg + {b_reg[61:0], 2'b00};
    assign c1 = c_reg ^ a_reg;
    assign d1 = d_reg ^ b_reg;
    assign b1 = b_reg ^ c1;
    assign a1 = a_reg ^ d1;
    assign c2 = c1 ^ {b_reg[46:0], 17'b0};

    always_comb
    begin
        phase_next = phase_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        count_next = count_reg;
        step       = 1'b0;
        unique case (phase_reg)
            bitadj_pkg::RNG_IDLE:
            begin
                if (ctrl.seed_go)
                begin
                    a_next     = seed_value;
                    b_next     = bitadj_pkg::SEED_ADD_B;
                    c_next     = bitadj_pkg::SEED_ADD_C;
                    d_next     = seed_value ^ bitadj_pkg::SEED_XOR_D;
                    m_next     = seed_value;
                    count_next = '0;
                    phase_next = bitadj_pkg::RNG_MUL;
                end
                else if (ctrl.draw)
                begin
                    step = 1'b1;
                end
            end
            bitadj_pkg::RNG_MUL:
            begin
                if (bitadj_pkg::SEED_MUL_B[count_reg[5:0]])
                begin
                    b_next = b_reg + m_reg;
                end
                if (bitadj_pkg::SEED_MUL_C[count_reg[5:0]])
                begin
                    c_next = c_reg + m_reg;
                end
                m_next     = {m_reg[62:0], 1'b0};
                count_next = count_reg + 1'b1;
                if (count_reg == 7'd63)
                begin
                    count_next = '0;
                    phase_next = bitadj_pkg::RNG_WARM;
                end
            end
            bitadj_pkg::RNG_WARM:
            begin
                step       = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == bitadj_pkg::WARM_DRAWS - 1'b1)
                begin
                    phase_next = bitadj_pkg::RNG_IDLE;
                end
            end
            default:
            begin
                phase_next = bitadj_pkg::RNG_IDLE;
            end
        endcase
        if (step)
        begin
            a_next = a1;
            b_next = b1;
            c_next = c2;
            d_next = {d1[18:0], d1[63:19]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bitadj_pkg::RNG_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
    end

    assign stat.busy      = phase_reg != bitadj_pkg::RNG_IDLE;
    assign stat.draw_zero = b5[59:57] == 3'b000;

endmodule

@@ rtl/core/bit_adjacency_neuron_pool.sv @@
// Neuron pool top level: command sequencer around the level and adjacency memories.
// One request is taken at a time and gives one result. After reset, and for the clear
// opcode, a sweep writes zero to every adjacency word and to the level of every neuron;
// no request is taken during it. In a settle step the scan of each row reads the level
// of every active neuron, one per cycle, through the single read port of the level
// memory, and keeps those of linked neighbours; their sum, SUM_W bits wide (14 at 64
// neurons), then goes through the serial divider. Hebbian learning checks each firing
// neuron against every later active neuron and may write a link for each such pair.
`include "bit_adjacency_neuron_pool_macros.svh"

module bit_adjacency_neuron_pool #(
    parameter int NEURONS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  opcode,
    input  logic [5:0]  first_neuron,
    input  logic [5:0]  second_neuron,
    input  logic [7:0]  state_value,
    input  logic [6:0]  grow_amount,
    input  logic [7:0]  step_limit,
    input  logic        reward_positive,
    input  logic [63:0] seed_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_level,
    output logic        firing_bit,
    output logic [7:0]  steps_taken,
    output logic [6:0]  neighbour_count,
    output logic [6:0]  grown_count,
    output logic [6:0]  pool_size
);

    localparam int ROW_WORDS = (NEURONS + 63) / 64;
    localparam int ADJ_DEPTH = NEURONS * ROW_WORDS;
    localparam int CNT_W     = $clog2(NEURONS + 1);
    localparam int L_AW      = $clog2(2 * NEURONS);
    localparam int A_AW      = $clog2(ADJ_DEPTH);
    localparam int SUM_W     = $clog2(255 * NEURONS + 1);
    localparam int DEG_W     = $clog2(ROW_WORDS * 64 + 1);
    localparam int GW        = CNT_W + 8;

    function automatic logic [L_AW-1:0] lvl_addr(input logic [CNT_W-1:0] x);
        return L_AW'(x);
    endfunction

    function automatic logic [L_AW-1:0] nxt_addr(input logic [CNT_W-1:0] x);
        return L_AW'(x) + L_AW'(NEURONS);
    endfunction

    function automatic logic [A_AW-1:0] adj_addr(input logic [CNT_W-1:0] row,
                                                 input logic [CNT_W-1:0] wd);
        return A_AW'(row) * A_AW'(ROW_WORDS) + A_AW'(wd);
    endfunction

    // Control registers.
    bitadj_pkg::pool_state_t state_reg, state_next;
    logic [7:0]       thr_reg, thr_next;
    logic [CNT_W-1:0] active_reg, active_next;
    logic             out_valid_reg, out_valid_next;
    logic [A_AW-1:0]  clr_reg, clr_next;
    logic             clr_ack_reg, clr_ack_next;
    logic             pend_reg, pend_next;
    logic             cap_reg, cap_next;

    // Working registers.
    bitadj_pkg::opcode_t op_reg, op_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [7:0]       lim_reg, lim_next;
    logic             rew_reg, rew_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] lx_reg, lx_next;
    logic [CNT_W-1:0] ly_reg, ly_next;
    logic             lon_reg, lon_next;
    logic [7:0]       self_reg, self_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             chg_reg, chg_next;
    logic [7:0]       step_reg, step_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic [6:0]       grown_reg, grown_next;
    logic [7:0]       rd_reg, rd_next;
    logic [7:0]       steps_reg, steps_next;

    // Output registers.
    logic [7:0] read_level_reg, read_level_next;
    logic       firing_bit_reg, firing_bit_next;
    logic [7:0] steps_taken_reg, steps_taken_next;
    logic [6:0] neighbour_count_reg, neighbour_count_next;
    logic [6:0] grown_count_reg, grown_count_next;
    logic [6:0] pool_size_reg, pool_size_next;

    // Memory ports.
    logic            l_we, l_re, a_we, a_re;
    logic [L_AW-1:0] l_waddr, l_raddr;
    logic [7:0]      l_wdata, l_q;
    logic [A_AW-1:0] a_waddr, a_raddr;
    logic [63:0]     a_wdata, a_q;

    logic             div_start, div_busy;
    logic [SUM_W-1:0] div_quot;

    bitadj_pkg::rng_ctrl_t rng_ctrl;
    bitadj_pkg::rng_stat_t rng_stat;

    logic [CNT_W-1:0] jd;
    logic [GW-1:0]    grow_sum;
    logic [CNT_W-1:0] grow_end;
    logic [9:0]       blend;
    logic [7:0]       mixed;
    logic [7:0]       new_level;
    logic [63:0]      link_bit;
    logic             in_fire;

    bitadj_ram #(.WIDTH(8), .DEPTH(2 * NEURONS)) u_level_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_q)
    );

    bitadj_ram #(.WIDTH(64), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_q)
    );

    bitadj_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (cnt_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    bitadj_rng u_rng (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (rng_ctrl),
        .seed_value (seed_value),
        .stat       (rng_stat)
    );

    assign jd       = CNT_W'(j_reg - 1'b1);
    assign grow_sum = GW'(active_reg) + GW'(grow_amount);
    assign grow_end = (grow_sum > GW'(NEURONS)) ? CNT_W'(NEURONS) : CNT_W'(grow_sum);
    assign blend    = {2'b00, self_reg} + {1'b0, self_reg, 1'b0} + {2'b00, div_quot[7:0]};
    assign mixed    = blend[9:2];
    assign link_bit = 64'd1 << 6'(ly_reg);
    assign in_fire  = l_q > bitadj_pkg::FIRE_LEVEL;

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            new_level = self_reg;
        end
        else if (mixed > thr_reg)
        begin
            new_level = bitadj_pkg::LEVEL_MAX;
        end
        else if (mixed < {1'b0, thr_reg[7:1]})
        begin
            new_level = '0;
        end
        else
        begin
            new_level = mixed;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        thr_next       = thr_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        clr_next       = clr_reg;
        clr_ack_next   = clr_ack_reg;
        pend_next      = pend_reg;
        cap_next       = cap_reg;
        op_next        = op_reg;
        row_next       = row_reg;
        lim_next       = lim_reg;
        rew_next       = rew_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        end_next       = end_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        lon_next       = lon_reg;
        self_next      = self_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        chg_next       = chg_reg;
        step_next      = step_reg;
        deg_next       = deg_reg;
        grown_next     = grown_reg;
        rd_next        = rd_reg;
        steps_next     = steps_reg;

        read_level_next      = read_level_reg;
        firing_bit_next      = firing_bit_reg;
        steps_taken_next     = steps_taken_reg;
        neighbour_count_next = neighbour_count_reg;
        grown_count_next     = grown_count_reg;
        pool_size_next       = pool_size_reg;

        l_we      = 1'b0;
        l_waddr   = '0;
        l_wdata   = '0;
        l_re      = 1'b0;
        l_raddr   = '0;
        a_we      = 1'b0;
        a_waddr   = '0;
        a_wdata   = '0;
        a_re      = 1'b0;
        a_raddr   = '0;
        div_start = 1'b0;
        rng_ctrl  = '0;
        in_ready  = 1'b0;

        if (cfg_valid)
        begin
            thr_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bitadj_pkg::ST_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                if (32'(clr_reg) < NEURONS)
                begin
                    l_we    = 1'b1;
                    l_waddr = L_AW'(clr_reg);
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == A_AW'(ADJ_DEPTH - 1))
                begin
                    active_next = '0;
                    state_next  = clr_ack_reg ? bitadj_pkg::ST_FINISH : bitadj_pkg::ST_IDLE;
                end
            end
            bitadj_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = bitadj_pkg::opcode_t'(opcode);
                    row_next   = CNT_W'(first_neuron);
                    lim_next   = step_limit;
                    rew_next   = reward_positive;
                    lx_next    = CNT_W'(first_neuron);
                    ly_next    = CNT_W'(second_neuron);
                    rd_next    = '0;
                    steps_next = '0;
                    deg_next   = '0;
                    grown_next = '0;
                    pend_next  = 1'b0;
                    state_next = bitadj_pkg::ST_FINISH;
                    case (bitadj_pkg::opcode_t'(opcode))
                        bitadj_pkg::OP_CLEAR:
                        begin
                            clr_next     = '0;
                            clr_ack_next = 1'b1;
                            state_next   = bitadj_pkg::ST_CLEAR;
                        end
                        bitadj_pkg::OP_GROW:
                        begin
                            i_next     = active_reg;
                            end_next   = grow_end;
                            grown_next = 7'(grow_end - active_reg);
                            state_next = bitadj_pkg::ST_GROW;
                        end
                        bitadj_pkg::OP_CONNECT:
                        begin
                            lon_next = 1'b1;
                            if (32'(first_neuron) < NEURONS && 32'(second_neuron) < NEURONS
                                && first_neuron != second_neuron)
                            begin
                                state_next = bitadj_pkg::ST_LINK_RA;
                            end
                        end
                        bitadj_pkg::OP_DISCONNECT:
                        begin
                            lon_next = 1'b0;
                            if (32'(first_neuron) < NEURONS && 32'(second_neuron) < NEURONS)
                            begin
                                state_next = bitadj_pkg::ST_LINK_RA;
                            end
                        end
                        bitadj_pkg::OP_WRITE:
                        begin
                            if (32'(first_neuron) < NEURONS)
                            begin
                                l_we    = 1'b1;
                                l_waddr = lvl_addr(CNT_W'(first_neuron));
                                l_wdata = state_value;
                            end
                        end
                        bitadj_pkg::OP_READ:
                        begin
                            if (32'(first_neuron) < NEURONS)
                            begin
                                l_re       = 1'b1;
                                l_raddr    = lvl_addr(CNT_W'(first_neuron));
                                state_next = bitadj_pkg::ST_READ_W;
                            end
                        end
                        bitadj_pkg::OP_DEGREE:
                        begin
                            if (32'(first_neuron) < NEURONS)
                            begin
                                // The active count never exceeds the pool, so no clip.
                                j_next     = '0;
                                end_next   = CNT_W'((GW'(active_reg) + GW'(63)) >> 6);
                                state_next = bitadj_pkg::ST_DEG;
                            end
                        end
                        bitadj_pkg::OP_SETTLE:
                        begin
                            step_next  = '0;
                            state_next = bitadj_pkg::ST_SETTLE;
                        end
                        bitadj_pkg::OP_HEBBIAN:
                        begin
                            i_next     = '0;
                            state_next = bitadj_pkg::ST_HEB_I;
                        end
                        bitadj_pkg::OP_SEED:
                        begin
                            rng_ctrl.seed_go = 1'b1;
                            state_next       = bitadj_pkg::ST_SEED;
                        end
                        default:
                        begin
                            state_next = bitadj_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            bitadj_pkg::ST_GROW:
            begin
                if (i_reg < end_reg)
                begin
                    l_we    = 1'b1;
                    l_waddr = lvl_addr(i_reg);
                    i_next  = i_reg + 1'b1;
                end
                else
                begin
                    active_next = end_reg;
                    state_next  = bitadj_pkg::ST_FINISH;
                end
            end
            bitadj_pkg::ST_LINK_RA:
            begin
                a_re       = 1'b1;
                a_raddr    = adj_addr(lx_reg, ly_reg >> 6);
                state_next = bitadj_pkg::ST_LINK_WA;
            end
            bitadj_pkg::ST_LINK_WA:
            begin
                a_we       = 1'b1;
                a_waddr    = adj_addr(lx_reg, ly_reg >> 6);
                a_wdata    = lon_reg ? (a_q | link_bit) : (a_q & ~link_bit);
                state_next = bitadj_pkg::ST_LINK_RB;
            end
            bitadj_pkg::ST_LINK_RB:
            begin
                a_re       = 1'b1;
                a_raddr    = adj_addr(ly_reg, lx_reg >> 6);
                state_next = bitadj_pkg::ST_LINK_WB;
            end
            bitadj_pkg::ST_LINK_WB:
            begin
                a_we    = 1'b1;
                a_waddr = adj_addr(ly_reg, lx_reg >> 6);
                a_wdata = lon_reg ? (a_q | (64'd1 << 6'(lx_reg)))
                                  : (a_q & ~(64'd1 << 6'(lx_reg)));
                if (op_reg == bitadj_pkg::OP_HEBBIAN)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = bitadj_pkg::ST_HEB_J;
                end
                else
                begin
                    state_next = bitadj_pkg::ST_FINISH;
                end
            end
            bitadj_pkg::ST_READ_W:
            begin
                rd_next    = l_q;
                state_next = bitadj_pkg::ST_FINISH;
            end
            bitadj_pkg::ST_DEG:
            begin
                if (pend_reg)
                begin
                    deg_next = deg_reg + DEG_W'(bitadj_pkg::popcount64(a_q));
                end
                if (j_reg < end_reg)
                begin
                    a_re      = 1'b1;
                    a_raddr   = adj_addr(row_reg, j_reg);
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = bitadj_pkg::ST_FINISH;
                end
            end
            bitadj_pkg::ST_SETTLE:
            begin
                if (step_reg == lim_reg)
                begin
                    steps_next = lim_reg;
                    state_next = bitadj_pkg::ST_FINISH;
                end
                else
                begin
                    i_next     = '0;
                    chg_next   = 1'b0;
                    state_next = bitadj_pkg::ST_P_SELF;
                end
            end
            bitadj_pkg::ST_P_SELF:
            begin
                j_next    = '0;
                pend_next = 1'b0;
                if (i_reg < active_reg)
                begin
                    l_re       = 1'b1;
                    l_raddr    = lvl_addr(i_reg);
                    cap_next   = 1'b1;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = bitadj_pkg::ST_P_SCAN;
                end
                else
                begin
                    state_next = bitadj_pkg::ST_COPY;
                end
            end
            bitadj_pkg::ST_P_SCAN:
            begin
                if (cap_reg)
                begin
                    self_next = l_q;
                    cap_next  = 1'b0;
                end
                if (pend_reg && a_q[6'(jd)])
                begin
                    sum_next = sum_reg + SUM_W'(l_q);
                    cnt_next = cnt_reg + 1'b1;
                end
                if (j_reg < active_reg)
                begin
                    l_re      = 1'b1;
                    l_raddr   = lvl_addr(j_reg);
                    a_re      = 1'b1;
                    a_raddr   = adj_addr(i_reg, j_reg >> 6);
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    div_start  = cnt_reg != '0;
                    state_next = bitadj_pkg::ST_P_DIV;
                end
            end
            bitadj_pkg::ST_P_DIV:
            begin
                if (!div_busy)
                begin
                    l_we       = 1'b1;
                    l_waddr    = nxt_addr(i_reg);
                    l_wdata    = new_level;
                    chg_next   = chg_reg || (new_level != self_reg);
                    i_next     = i_reg + 1'b1;
                    state_next = bitadj_pkg::ST_P_SELF;
                end
            end
            bitadj_pkg::ST_COPY:
            begin
                // Scratch levels are written back in the cycle after their reads.
                if (pend_reg)
                begin
                    l_we    = 1'b1;
                    l_waddr = lvl_addr(jd);
                    l_wdata = l_q;
                end
                if (j_reg < active_reg)
                begin
                    l_re      = 1'b1;
                    l_raddr   = nxt_addr(j_reg);
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = bitadj_pkg::ST_STEP_END;
                end
            end
            bitadj_pkg::ST_STEP_END:
            begin
                if (!chg_reg)
                begin
                    steps_next = step_reg;
                    state_next = bitadj_pkg::ST_FINISH;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = bitadj_pkg::ST_SETTLE;
                end
            end
            bitadj_pkg::ST_HEB_I:
            begin
                if (i_reg < active_reg)
                begin
                    l_re       = 1'b1;
                    l_raddr    = lvl_addr(i_reg);
                    state_next = bitadj_pkg::ST_HEB_IW;
                end
                else
                begin
                    state_next = bitadj_pkg::ST_FINISH;
                end
            end
            bitadj_pkg::ST_HEB_IW:
            begin
                if (in_fire)
                begin
                    j_next     = i_reg + 1'b1;
                    state_next = bitadj_pkg::ST_HEB_J;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = bitadj_pkg::ST_HEB_I;
                end
            end
            bitadj_pkg::ST_HEB_J:
            begin
                if (j_reg < active_reg)
                begin
                    l_re       = 1'b1;
                    l_raddr    = lvl_addr(j_reg);
                    state_next = bitadj_pkg::ST_HEB_JW;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = bitadj_pkg::ST_HEB_I;
                end
            end
            bitadj_pkg::ST_HEB_JW:
            begin
                lx_next    = i_reg;
                ly_next    = j_reg;
                j_next     = j_reg + 1'b1;
                state_next = bitadj_pkg::ST_HEB_J;
                if (in_fire)
                begin
                    if (rew_reg)
                    begin
                        lon_next   = 1'b1;
                        j_next     = j_reg;
                        state_next = bitadj_pkg::ST_LINK_RA;
                    end
                    else
                    begin
                        // Every punished pair consumes one draw.
                        rng_ctrl.draw = 1'b1;
                        if (rng_stat.draw_zero)
                        begin
                            lon_next   = 1'b0;
                            j_next     = j_reg;
                            state_next = bitadj_pkg::ST_LINK_RA;
                        end
                    end
                end
            end
            bitadj_pkg::ST_SEED:
            begin
                if (!rng_stat.busy)
                begin
                    state_next = bitadj_pkg::ST_FINISH;
                end
            end
            bitadj_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    read_level_next      = rd_reg;
                    firing_bit_next      = rd_reg > bitadj_pkg::FIRE_LEVEL;
                    steps_taken_next     = steps_reg;
                    neighbour_count_next = (deg_reg > DEG_W'(bitadj_pkg::DEGREE_MAX))
                                           ? bitadj_pkg::DEGREE_MAX : 7'(deg_reg);
                    grown_count_next     = grown_reg;
                    pool_size_next       = 7'(active_reg);
                    clr_ack_next         = 1'b0;
                    state_next           = bitadj_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bitadj_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bitadj_pkg::ST_CLEAR;
            thr_reg       <= bitadj_pkg::FIRE_LEVEL;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
            clr_ack_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            cap_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
            clr_ack_reg   <= clr_ack_next;
            pend_reg      <= pend_next;
            cap_reg       <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg              <= op_next;
        row_reg             <= row_next;
        lim_reg             <= lim_next;
        rew_reg             <= rew_next;
        i_reg               <= i_next;
        j_reg               <= j_next;
        end_reg             <= end_next;
        lx_reg              <= lx_next;
        ly_reg              <= ly_next;
        lon_reg             <= lon_next;
        self_reg            <= self_next;
        sum_reg             <= sum_next;
        cnt_reg             <= cnt_next;
        chg_reg             <= chg_next;
        step_reg            <= step_next;
        deg_reg             <= deg_next;
        grown_reg           <= grown_next;
        rd_reg              <= rd_next;
        steps_reg           <= steps_next;
        read_level_reg      <= read_level_next;
        firing_bit_reg      <= firing_bit_next;
        steps_taken_reg     <= steps_taken_next;
        neighbour_count_reg <= neighbour_count_next;
        grown_count_reg     <= grown_count_next;
        pool_size_reg       <= pool_size_next;
    end

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign read_level      = read_level_reg;
    assign firing_bit      = firing_bit_reg;
    assign steps_taken     = steps_taken_reg;
    assign neighbour_count = neighbour_count_reg;
    assign grown_count     = grown_count_reg;
    assign pool_size       = pool_size_reg;

    `BITADJ_AST_IMP(a_div_not_restarted, div_start, !div_busy, "divider restarted while busy")
    `BITADJ_AST_IMP(a_draw_not_seeding, rng_ctrl.draw, !rng_stat.busy, "draw during seeding")
    `BITADJ_AST_IMP(a_pool_bound, 1'b1, 32'(active_reg) <= NEURONS, "active count past pool")
    `BITADJ_AST_NXT(a_finish_posts,
                    state_reg == bitadj_pkg::ST_FINISH && !out_valid_reg,
                    out_valid_reg, "finished request gave no result")

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the bit-adjacency neuron pool.
`timescale 1ns / 1ps

module tb;

    localparam int         POOL_N      = 64;
    localparam int         CYCLE_LIMIT = 4000000;
    localparam logic [3:0] OP_SPARE_LO = 4'd10;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    typedef struct {
        logic [7:0] level;
        logic       fire;
        logic [7:0] steps;
        logic [6:0] degree;
        logic [6:0] grown;
        logic [6:0] pool;
    } pool_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  opcode;
    logic [5:0]  first_neuron;
    logic [5:0]  second_neuron;
    logic [7:0]  state_value;
    logic [6:0]  grow_amount;
    logic [7:0]  step_limit;
    logic        reward_positive;
    logic [63:0] seed_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_level;
    logic        firing_bit;
    logic [7:0]  steps_taken;
    logic [6:0]  neighbour_count;
    logic [6:0]  grown_count;
    logic [6:0]  pool_size;

    // Shadow copy of the pool.
    logic [7:0]  nlevel [POOL_N];
    logic [63:0] links [POOL_N];
    int          active_n;
    logic [63:0] gen_words [4];
    logic [7:0]  fire_thr;

    pool_result_t pending_results[$];
    int  errors;
    int  cycles;
    int  sink_hold;
    bit  quiet;

    bit_adjacency_neuron_pool #(.NEURONS(POOL_N)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .first_neuron(first_neuron), .second_neuron(second_neuron),
        .state_value(state_value), .grow_amount(grow_amount), .step_limit(step_limit),
        .reward_positive(reward_positive), .seed_value(seed_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_level(read_level), .firing_bit(firing_bit), .steps_taken(steps_taken),
        .neighbour_count(neighbour_count), .grown_count(grown_count),
        .pool_size(pool_size)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rotl(input logic [63:0] x, input int k);
        return (x << k) | (x >> (64 - k));
    endfunction

    function automatic logic [63:0] gen_draw();
        logic [63:0] a, b, c, d, r, t;
        a = gen_words[0];
        b = gen_words[1];
        c = gen_words[2];
        d = gen_words[3];
        r = rotl(b * 64'd5, 7) * 64'd9;
        t = b << 17;
        c ^= a; d ^= b; b ^= c; a ^= d; c ^= t; d = rotl(d, 45);
        gen_words[0] = a;
        gen_words[1] = b;
        gen_words[2] = c;
        gen_words[3] = d;
        return r;
    endfunction

    function automatic void link_pair(input int i, input int j, input bit on);
        links[i][j] = on;
        links[j][i] = on;
    endfunction

    function automatic void step_once();
        logic [7:0] nxt [POOL_N];
        int sum, cnt, v;
        nxt = nlevel;
        for (int i = 0; i < active_n; i++)
        begin
            sum = 0;
            cnt = 0;
            for (int j = 0; j < active_n; j++)
            begin
                if (links[i][j])
                begin
                    sum += nlevel[j];
                    cnt++;
                end
            end
            if (cnt == 0)
                continue;
            v = (nlevel[i] * 3 + sum / cnt) / 4;
            if (v > fire_thr)
                v = 255;
            else if (v < fire_thr / 2)
                v = 0;
            nxt[i] = v[7:0];
        end
        nlevel = nxt;
    endfunction

    function automatic int settle_steps(input int limit);
        logic [7:0] prior [POOL_N];
        bit same;
        for (int s = 0; s < limit; s++)
        begin
            prior = nlevel;
            step_once();
            same = 1;
            for (int k = 0; k < active_n; k++)
                if (prior[k] != nlevel[k])
                    same = 0;
            if (same)
                return s;
        end
        return limit;
    endfunction

    function automatic void learn(input bit reward);
        logic [63:0] r;
        for (int i = 0; i < active_n; i++)
        begin
            if (nlevel[i] <= 128)
                continue;
            for (int j = i + 1; j < active_n; j++)
            begin
                if (nlevel[j] <= 128)
                    continue;
                if (reward)
                    link_pair(i, j, 1);
                else
                begin
                    r = gen_draw();
                    if (r[2:0] == 3'd0)
                        link_pair(i, j, 0);
                end
            end
        end
    endfunction

    function automatic pool_result_t predict_pool_op();
        pool_result_t res;
        int stop;
        logic [63:0] s;
        res = '{default: '0};
        case (opcode)
            bitadj_pkg::OP_CLEAR:
            begin
                for (int k = 0; k < POOL_N; k++)
                begin
                    nlevel[k] = '0;
                    links[k] = '0;
                end
                active_n = 0;
            end
            bitadj_pkg::OP_GROW:
            begin
                stop = active_n + grow_amount;
                if (stop > POOL_N)
                    stop = POOL_N;
                for (int k = active_n; k < stop; k++)
                    nlevel[k] = '0;
                res.grown = 7'(stop - active_n);
                active_n = stop;
            end
            bitadj_pkg::OP_CONNECT:
                if (first_neuron != second_neuron)
                    link_pair(first_neuron, second_neuron, 1);
            bitadj_pkg::OP_DISCONNECT:
                link_pair(first_neuron, second_neuron, 0);
            bitadj_pkg::OP_WRITE:
                nlevel[first_neuron] = state_value;
            bitadj_pkg::OP_READ:
            begin
                res.level = nlevel[first_neuron];
                res.fire = nlevel[first_neuron] > 128;
            end
            bitadj_pkg::OP_DEGREE:
                if (active_n > 0)
                    res.degree = 7'($countones(links[first_neuron]));
            bitadj_pkg::OP_SETTLE:
                res.steps = 8'(settle_steps(step_limit));
            bitadj_pkg::OP_HEBBIAN:
                learn(reward_positive);
            bitadj_pkg::OP_SEED:
            begin
                s = seed_value;
                gen_words[0] = s;
                gen_words[1] = s * 64'd6364136223846793005 + 64'd1;
                gen_words[2] = s * 64'd1103515245 + 64'd12345;
                gen_words[3] = s ^ 64'hdeadbeefcafebabe;
                for (int k = 0; k < 20; k++)
                    void'(gen_draw());
            end
            default: ;
        endcase
        res.pool = 7'(active_n);
        return res;
    endfunction

    // Sends one request; called at a falling edge, returns at a falling edge.
    task automatic send_request(input logic [3:0] op, input int a, input int b,
                                input int val, input int amt, input int lim,
                                input bit rew, input logic [63:0] sd);
        begin
            opcode = op;
            first_neuron = 6'(a);
            second_neuron = 6'(b);
            state_value = 8'(val);
            grow_amount = 7'(amt);
            step_limit = 8'(lim);
            reward_positive = rew;
            seed_value = sd;
            in_valid = 1;
            do @(posedge clk); while (!in_ready);
            pending_results.push_back(predict_pool_op());
            @(negedge clk);
            in_valid = 0;
            if (!quiet && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic drain();
        begin
            while (pending_results.size() != 0)
                @(negedge clk);
            repeat (20) @(negedge clk);
        end
    endtask

    task automatic write_threshold(input logic [7:0] value);
        begin
            drain();
            cfg_data = value;
            cfg_valid = 1;
            do @(posedge clk); while (!cfg_ready);
            fire_thr = value;
            @(negedge clk);
            cfg_valid = 0;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            out_ready <= 0;
            sink_hold <= sink_hold - 1;
        end
        else if (!quiet && $urandom_range(0, 15) == 0)
        begin
            out_ready <= 0;
            sink_hold <= $urandom_range(0, 17);
        end
        else
            out_ready <= 1;
    end

    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result at cycle %0d", cycles);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_level !== want.level || firing_bit !== want.fire
                    || steps_taken !== want.steps || neighbour_count !== want.degree
                    || grown_count !== want.grown || pool_size !== want.pool)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp lvl %0d f %0d st %0d deg %0d gr %0d pool %0d",
                                 want.level, want.fire, want.steps, want.degree,
                                 want.grown, want.pool,
                                 ", got lvl %0d f %0d st %0d deg %0d gr %0d pool %0d",
                                 read_level, firing_bit, steps_taken, neighbour_count,
                                 grown_count, pool_size);
                end
            end
        end
    end

    task automatic test_directed();
        begin
            send_request(bitadj_pkg::OP_READ, 0, 0, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_DEGREE, 63, 0, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_SETTLE, 0, 0, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_GROW, 0, 0, 0, 64, 0, 0, '0);
            send_request(bitadj_pkg::OP_GROW, 0, 0, 0, 5, 0, 0, '0);
            send_request(bitadj_pkg::OP_WRITE, 63, 0, 255, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_WRITE, 0, 0, 200, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_CONNECT, 0, 63, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_CONNECT, 5, 5, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_DEGREE, 0, 0, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_SETTLE, 0, 0, 0, 0, 1, 0, '0);
            send_request(bitadj_pkg::OP_HEBBIAN, 0, 0, 0, 0, 0, 1, '0);
            // Without a seed every draw is zero, so all co-active pairs are cut.
            send_request(bitadj_pkg::OP_HEBBIAN, 0, 0, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_READ, 63, 0, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_DISCONNECT, 63, 0, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_SEED, 0, 0, 0, 0, 0, 0, '1);
            send_request(bitadj_pkg::OP_SEED, 0, 0, 0, 0, 0, 0, '0);
            send_request(OP_SPARE_LO, 42, 21, 170, 85, 170, 1, '0);
            send_request(OP_SPARE_HI, 21, 42, 85, 42, 85, 0, '1);
            send_request(bitadj_pkg::OP_GROW, 0, 0, 0, 4, 0, 0, '0);
            send_request(bitadj_pkg::OP_WRITE, 1, 0, 240, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_CONNECT, 1, 2, 0, 0, 0, 0, '0);
            send_request(bitadj_pkg::OP_SETTLE, 0, 0, 0, 0, 255, 0, '0);
            send_request(bitadj_pkg::OP_READ, 2, 0, 0, 0, 0, 0, '0);
        end
    endtask

    task automatic test_random(input int count);
        int pick;
        int lim;
        logic [63:0] sd;
        begin
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(0, 99);
                lim = ($urandom_range(0, 9) == 0 && active_n <= 8)
                      ? 255 : $urandom_range(0, 6);
                sd = {$urandom, $urandom};
                if (active_n > 16 && pick < 30)
                    send_request(bitadj_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, sd);
                else if (pick < 12)
                    send_request(bitadj_pkg::OP_GROW, 0, 0, 0, $urandom_range(0, 5),
                                 0, 0, sd);
                else if (pick < 30)
                    send_request(bitadj_pkg::OP_WRITE, $urandom_range(0, active_n + 1), 0,
                                 $urandom_range(0, 255), 0, 0, 0, sd);
                else if (pick < 45)
                    send_request(bitadj_pkg::OP_CONNECT, $urandom_range(0, active_n + 1),
                                 $urandom_range(0, active_n + 1), 0, 0, 0, 0, sd);
                else if (pick < 50)
                    send_request(bitadj_pkg::OP_DISCONNECT, $urandom_range(0, active_n + 1),
                                 $urandom_range(0, active_n + 1), 0, 0, 0, 0, sd);
                else if (pick < 60)
                    send_request(bitadj_pkg::OP_READ, $urandom_range(0, 63), 0, 0, 0, 0, 0,
                                 sd);
                else if (pick < 67)
                    send_request(bitadj_pkg::OP_DEGREE, $urandom_range(0, 63), 0, 0, 0, 0,
                                 0, sd);
                else if (pick < 80)
                    send_request(bitadj_pkg::OP_SETTLE, 0, 0, 0, 0, lim, 0, sd);
                else if (pick < 90)
                    send_request(bitadj_pkg::OP_HEBBIAN, 0, 0, 0, 0, 0,
                                 $urandom_range(0, 1), sd);
                else if (pick < 94)
                    send_request(bitadj_pkg::OP_SEED, 0, 0, 0, 0, 0, 0, sd);
                else if (pick < 97)
                    send_request(4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                 $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 255), $urandom_range(0, 64),
                                 $urandom_range(0, 255), $urandom_range(0, 1), sd);
                else
                    send_request(bitadj_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, sd);
            end
        end
    endtask

    task automatic test_backpressure();
        begin
            drain();
            // Set the hold-off away from the falling edge where the receiver updates it.
            @(posedge clk);
            sink_hold = 400;
            @(negedge clk);
            for (int n = 0; n < 6; n++)
                send_request(bitadj_pkg::OP_WRITE, n, 0, 40 * n, 0, 0, 0, '0);
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        in_valid = 0;
        opcode = '0;
        first_neuron = '0;
        second_neuron = '0;
        state_value = '0;
        grow_amount = '0;
        step_limit = '0;
        reward_positive = 0;
        seed_value = '0;
        out_ready = 0;
        errors = 0;
        cycles = 0;
        sink_hold = 0;
        quiet = 0;
        fire_thr = 8'd128;
        active_n = 0;
        for (int k = 0; k < POOL_N; k++)
        begin
            nlevel[k] = '0;
            links[k] = '0;
        end
        for (int k = 0; k < 4; k++)
            gen_words[k] = '0;
        repeat (7) @(negedge clk);
        rst_n = 1;

        test_directed();
        write_threshold(8'd0);
        test_random(20);
        write_threshold(8'd255);
        test_random(20);
        test_backpressure();
        write_threshold(8'($urandom_range(1, 254)));
        test_random(35);
        write_threshold(8'd128);
        quiet = 1;
        test_random(35);

        drain();
        repeat (100) @(negedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bitadj_pkg.sv
rtl/core/bitadj_ram.sv
rtl/core/bitadj_div.sv
rtl/core/bitadj_rng.sv
rtl/core/bit_adjacency_neuron_pool.sv
bench/tb.sv
